### rtl/a85_pkg.sv
// shared types and constants of the ascii85 stream encoder
`default_nettype none

package a85_pkg;

  localparam int unsigned DIGIT_BASE   = 85;
  localparam int unsigned DIGIT_OFFSET = 33;
  localparam int unsigned NUM_DIGITS   = 5;
  localparam logic [6:0]  ZERO_CHAR    = 7'd122;

  // ceil(2^38 / 85): (n * RECIP) >> 38 is exact n / 85 for every 32-bit n
  localparam logic [31:0] RECIP        = 32'd3233857729;
  localparam int unsigned RECIP_SHIFT  = 38;
  localparam int unsigned QUO_W        = 64 - RECIP_SHIFT;

  localparam int unsigned JOBQ_DEPTH   = 2;

  localparam int unsigned CFG_ADDR_W   = 3;
  localparam logic        REG_ZSE      = 1'b0;

  typedef logic [6:0] char_t;

  typedef struct packed {
    logic [31:0] group;
    logic [2:0]  last_idx;
    logic        zero;
  } job_t;

endpackage

`default_nettype wire

### rtl/a85_front.sv
// byte packer: gathers bytes into groups and issues one job per closed group
`default_nettype none

module a85_front
  import a85_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic [7:0] data_byte,
  input  wire logic       end_of_stream,
  input  wire logic       zse,
  output logic            job_push,
  output job_t            job
);

  logic [31:0] acc;
  logic [1:0]  bytes_held;
  logic [31:0] acc_next;
  logic        close;

  always_comb begin
    // first byte lands in the top lane
    acc_next = acc | (32'(data_byte) << {~bytes_held, 3'b000});
    close    = (bytes_held == 2'd3) || end_of_stream;
    job_push = accept && close;
    job.group    = acc_next;
    job.last_idx = {1'b0, bytes_held} + 3'd1;
    job.zero     = (bytes_held == 2'd3) && (acc_next == 32'd0) && zse;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc        <= 32'd0;
      bytes_held <= 2'd0;
    end else if (accept) begin
      if (close) begin
        acc        <= 32'd0;
        bytes_held <= 2'd0;
      end else begin
        acc        <= acc_next;
        bytes_held <= bytes_held + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/a85_jobq.sv
// small job queue between packer and digit converter
`default_nettype none

module a85_jobq
  import a85_pkg::*;
#(
  parameter int unsigned Depth = JOBQ_DEPTH
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_job,
  output logic      full,
  input  wire logic rd_en,
  output job_t      rd_job,
  output logic      not_empty
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr;
  logic [PtrW-1:0] rd_ptr;
  logic [CntW-1:0] count;

  assign full      = (count == FullCnt);
  assign not_empty = (count != '0);
  assign rd_job    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_en) begin
        slots[wr_ptr] <= wr_job;
        wr_ptr <= (wr_ptr == LastPtr) ? '0 : wr_ptr + PtrW'(1);
      end
      if (rd_en) begin
        rd_ptr <= (rd_ptr == LastPtr) ? '0 : rd_ptr + PtrW'(1);
      end
      if (wr_en && !rd_en) begin
        count <= count + CntW'(1);
      end else if (!wr_en && rd_en) begin
        count <= count - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

### rtl/a85_back.sv
// digit converter (one divide by 85 per cycle) and character emitter
`default_nettype none

module a85_back
  import a85_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output logic      empty,
  input  wire logic pop,
  output char_t     out_char,
  output logic      last_char
);

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } conv_state_t;

  conv_state_t      state;
  logic [1:0]       step;
  logic [31:0]      val;
  logic [QUO_W-1:0] prod_q;
  logic [QUO_W-1:0] prod_q_next;
  logic [2:0]       cv_last;
  logic             cv_zero;
  char_t            digits [NUM_DIGITS];

  logic             em_valid;
  char_t            em_digits [NUM_DIGITS];
  logic [2:0]       em_idx;
  logic [2:0]       em_last_idx;
  logic             em_zero;
  logic             em_last;

  logic             handoff;
  logic             take;
  logic [31:0]      mult_a;
  logic [63:0]      mult;
  logic [31:0]      rem;

  always_comb begin
    em_last  = em_zero || (em_idx == em_last_idx);
    handoff  = (state == DONE) && (!em_valid || (pop && em_last));
    take     = job_valid && ((state == IDLE) || handoff);
    job_pop  = take;
    mult_a   = take ? job.group : 32'(prod_q);
    mult     = 64'(mult_a) * 64'(RECIP);
    prod_q_next = mult[63:RECIP_SHIFT];
    // prod_q holds the quotient of val, so this is val mod 85
    rem      = val - 32'(prod_q) * 32'(DIGIT_BASE);
    empty    = !em_valid;
    out_char = em_zero ? ZERO_CHAR : em_digits[em_idx] + 7'(DIGIT_OFFSET);
    last_char = em_last;
  end

  always_ff @(posedge clk) begin
    prod_q <= prod_q_next;
    if (rst) begin
      state    <= IDLE;
      step     <= 2'd0;
      em_valid <= 1'b0;
      em_idx   <= 3'd0;
    end else begin
      case (state)
        IDLE: begin
          if (take) begin
            state <= RUN;
          end
        end
        RUN: begin
          // digits come out least significant first
          digits[3'd4 - {1'b0, step}] <= rem[6:0];
          val  <= 32'(prod_q);
          step <= step + 2'd1;
          if (step == 2'd3) begin
            digits[0] <= prod_q[6:0];
            state <= DONE;
          end
        end
        DONE: begin
          if (handoff) begin
            state <= take ? RUN : IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase

      if (take) begin
        val     <= job.group;
        cv_last <= job.last_idx;
        cv_zero <= job.zero;
        step    <= 2'd0;
      end

      if (handoff) begin
        em_valid    <= 1'b1;
        em_digits   <= digits;
        em_last_idx <= cv_last;
        em_zero     <= cv_zero;
        em_idx      <= 3'd0;
      end else if (pop && em_valid) begin
        if (em_last) begin
          em_valid <= 1'b0;
        end else begin
          em_idx <= em_idx + 3'd1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/ascii85_stream_encoder.sv
// ascii85 stream encoder, top level
//
// Input channel: one raw byte per beat (data_byte, end_of_stream), taken at
// a clock edge with push high and full low. Four bytes form a group; a beat
// with end_of_stream closes the group early (k bytes give k+1 characters).
// Result channel: one character per beat (out_char, last_char) shown while
// empty is low, taken with pop. last_char marks the final character of a
// group. A full all-zero group gives a single 'z' while zero_shortcut_enable
// (register 0, byte address 0, reset 1) is set.
// Timing: a closed group passes through the job queue, converter and the
// emitter register. The converter does one divide by 85 per cycle through a
// 32x32 reciprocal multiplier and takes a new group only at the handoff of
// the last one; the emitter sends one character per cycle while pop is high.
// A two-entry job queue between packer and converter lets bytes keep
// flowing while the receiver stalls; full rises only once that queue fills.
// Reset clears the partial group, the queue and the output, and sets
// zero_shortcut_enable.
`default_nettype none

module ascii85_stream_encoder
  import a85_pkg::*;
#(
  parameter int unsigned JobQDepth = JOBQ_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [7:0]            data_byte,
  input  wire logic                  end_of_stream,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [6:0]                 out_char,
  output logic                       last_char,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [CFG_ADDR_W-1:0] paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  logic zse;
  logic accept;
  logic job_push;
  job_t job_in;
  job_t job_out;
  logic job_valid;
  logic job_pop;

  assign pready = 1'b1;
  assign accept = push && !full;
  assign prdata = (paddr[2] == REG_ZSE) ? {31'd0, zse} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      zse <= 1'b1;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_ZSE)) begin
      zse <= pwdata[0];
    end
  end

  a85_front u_front (
    .clk          (clk),
    .rst          (rst),
    .accept       (accept),
    .data_byte    (data_byte),
    .end_of_stream(end_of_stream),
    .zse          (zse),
    .job_push     (job_push),
    .job          (job_in)
  );

  a85_jobq #(
    .Depth(JobQDepth)
  ) u_jobq (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_job   (job_in),
    .full     (full),
    .rd_en    (job_pop),
    .rd_job   (job_out),
    .not_empty(job_valid)
  );

  a85_back u_back (
    .clk      (clk),
    .rst      (rst),
    .job_valid(job_valid),
    .job      (job_out),
    .job_pop  (job_pop),
    .empty    (empty),
    .pop      (pop),
    .out_char (out_char),
    .last_char(last_char)
  );

endmodule

`default_nettype wire

### rtl/a85_checker.sv
// port-level checks for the ascii85 stream encoder, bound to the top level
`default_nettype none

module a85_checker
  import a85_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       full,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [6:0] out_char,
  input wire logic       last_char
);

  // every character is a base-85 digit or the zero shortcut
  a_char_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> ((out_char >= 7'd33) && (out_char <= 7'd117)) || (out_char == ZERO_CHAR))
    else $error("character outside the ascii85 alphabet");

  // 'z' always stands alone
  a_zero_alone: assert property (@(posedge clk) disable iff (rst)
    (!empty && (out_char == ZERO_CHAR)) |-> last_char)
    else $error("zero shortcut not marked as last character");

  // reset drains both sides
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("encoder not empty after reset");

  // a stalled character holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(out_char) && $stable(last_char)))
    else $error("waiting character changed under stall");

endmodule

bind ascii85_stream_encoder a85_checker u_a85_checker (.*);

`default_nettype wire
